// ===== design/stack_queue_engine_macros.svh =====
// Assertion helpers for the engine's control module.
`ifndef STACK_QUEUE_ENGINE_MACROS_SVH
`define STACK_QUEUE_ENGINE_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define SQE_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Trigger in one cycle implies outcome in the next.
`define SQE_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/sqe_pkg.sv =====
package sqe_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef logic signed [31:0] word_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		REQ_PUSH = 3'd0,
		REQ_LIST = 3'd1,
		REQ_PEEK = 3'd2,
		REQ_POP  = 3'd3,
		REQ_SWAP = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_SHORT      = 2'd1,
		ST_FULL       = 2'd2,
		ST_EMPTY_LIST = 2'd3
	} status_t;

	// Operation broadcast to every cell of the row.
	typedef enum logic [2:0] {
		CELL_HOLD       = 3'd0,
		CELL_PUSH_FRONT = 3'd1,
		CELL_PUSH_BACK  = 3'd2,
		CELL_POP        = 3'd3,
		CELL_SWAP       = 3'd4,
		CELL_ROT        = 3'd5
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		word_t    value;
		cnt_t     count;
	} cell_cmd_t;

endpackage

// ===== design/sqe_cell.sv =====
// One entry of the row. Cell 0 is the front.
module sqe_cell (
	input  logic              clk,
	input  sqe_pkg::idx_t     idx,
	input  sqe_pkg::cell_cmd_t cmd,
	input  sqe_pkg::word_t    left_d,
	input  sqe_pkg::word_t    right_d,
	input  sqe_pkg::word_t    front_d,
	output sqe_pkg::word_t    d
);

	sqe_pkg::word_t d_q;
	sqe_pkg::cnt_t  pos;
	sqe_pkg::cnt_t  pos_next;

	assign pos      = sqe_pkg::CNT_W'(idx);
	assign pos_next = pos + sqe_pkg::CNT_W'(1);
	assign d        = d_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			sqe_pkg::CELL_PUSH_FRONT: d_q <= left_d;
			sqe_pkg::CELL_PUSH_BACK: begin
				if (pos == cmd.count) d_q <= cmd.value;
			end
			sqe_pkg::CELL_POP: d_q <= right_d;
			sqe_pkg::CELL_SWAP: begin
				if (idx == sqe_pkg::IDX_W'(0)) d_q <= right_d;
				else if (idx == sqe_pkg::IDX_W'(1)) d_q <= left_d;
			end
			sqe_pkg::CELL_ROT: begin
				// front wraps around to the back of the occupied span
				if (pos_next == cmd.count) d_q <= front_d;
				else if (pos_next < cmd.count) d_q <= right_d;
			end
			default: ;
		endcase
	end

endmodule

// ===== design/sqe_ctrl.sv =====
`include "stack_queue_engine_macros.svh"

// Request decode, fill count, list sequencer and result register.
module sqe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         req_type,
	input  sqe_pkg::word_t     push_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output sqe_pkg::word_t     read_value,
	output logic               last,
	input  logic               cfg_valid,
	input  logic               cfg_data,
	input  sqe_pkg::word_t     front_d,
	output sqe_pkg::cell_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_LIST = 2'b10
	} state_t;

	state_t        state_q, state_d;
	sqe_pkg::cnt_t count_q, count_d;
	sqe_pkg::cnt_t rem_q, rem_d;
	logic          queue_mode_q;
	logic          out_valid_q;
	logic [1:0]    status_q;
	sqe_pkg::word_t read_value_q;
	logic          last_q;

	logic          out_free, in_acc, load, lst;
	logic [1:0]    st;
	sqe_pkg::word_t rv;
	logic          full, empty, short2;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q == S_LIST) || !out_free;
	assign in_acc   = in_valid && !in_stall;
	assign full     = (count_q == sqe_pkg::CNT_W'(sqe_pkg::DEPTH));
	assign empty    = (count_q == '0);
	assign short2   = (count_q < sqe_pkg::CNT_W'(2));

	always_comb begin
		cmd.op    = sqe_pkg::CELL_HOLD;
		cmd.value = push_value;
		cmd.count = count_q;
		load      = 1'b0;
		st        = sqe_pkg::ST_OK;
		rv        = '0;
		lst       = 1'b1;
		count_d   = count_q;
		rem_d     = rem_q;
		state_d   = state_q;
		if (state_q == S_LIST) begin
			if (out_free) begin
				cmd.op = sqe_pkg::CELL_ROT;
				load   = 1'b1;
				rv     = front_d;
				lst    = (rem_q == sqe_pkg::CNT_W'(1));
				rem_d  = rem_q - sqe_pkg::CNT_W'(1);
				if (lst) state_d = S_IDLE;
			end
		end else if (in_acc) begin
			case (req_type)
				sqe_pkg::REQ_PUSH: begin
					load = 1'b1;
					if (full) st = sqe_pkg::ST_FULL;
					else begin
						cmd.op  = queue_mode_q ? sqe_pkg::CELL_PUSH_BACK
						                       : sqe_pkg::CELL_PUSH_FRONT;
						count_d = count_q + sqe_pkg::CNT_W'(1);
					end
				end
				sqe_pkg::REQ_LIST: begin
					load = 1'b1;
					if (empty) st = sqe_pkg::ST_EMPTY_LIST;
					else begin
						cmd.op = sqe_pkg::CELL_ROT;
						rv     = front_d;
						lst    = (count_q == sqe_pkg::CNT_W'(1));
						if (!lst) begin
							state_d = S_LIST;
							rem_d   = count_q - sqe_pkg::CNT_W'(1);
						end
					end
				end
				sqe_pkg::REQ_PEEK: begin
					load = 1'b1;
					if (empty) st = sqe_pkg::ST_SHORT;
					else rv = front_d;
				end
				sqe_pkg::REQ_POP: begin
					load = 1'b1;
					if (empty) st = sqe_pkg::ST_SHORT;
					else begin
						cmd.op  = sqe_pkg::CELL_POP;
						count_d = count_q - sqe_pkg::CNT_W'(1);
					end
				end
				sqe_pkg::REQ_SWAP: begin
					load = 1'b1;
					if (short2) st = sqe_pkg::ST_SHORT;
					else cmd.op = sqe_pkg::CELL_SWAP;
				end
				default: ; // unused codes: dropped silently
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			rem_q        <= '0;
			queue_mode_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			if (cfg_valid) queue_mode_q <= cfg_data;
			if (out_free) out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load) begin
			status_q     <= st;
			read_value_q <= rv;
			last_q       <= lst;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign last       = last_q;

	`SQE_CHECK(a_count_bound, count_q <= sqe_pkg::CNT_W'(sqe_pkg::DEPTH), "count overflow")
	`SQE_CHECK(a_list_stalls, (state_q != S_LIST) || in_stall, "request taken while listing")
	`SQE_CHECK(a_list_rem, (state_q != S_LIST) || (rem_q != '0), "list running with no entries left")
	`SQE_NEXT(a_push_grows, in_acc && (req_type == sqe_pkg::REQ_PUSH) && !full, count_q == $past(count_q) + sqe_pkg::CNT_W'(1), "push did not grow count")

endmodule

// ===== design/stack_queue_engine.sv =====
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | req_type, push_value
// out     | output    | out_valid / out_stall| status, read_value, last
// cfg     | input     | cfg_valid / cfg_ready| cfg_data (queue mode)
//
// Push, pop, peek and swap each give one result; a new request is taken every
// cycle while the result register drains and no list runs. A list of n entries
// gives n results, one per cycle unless out_stall holds, from a one-step row rotation.
// Reset clears fill count, mode, list state and result valid; entries and
// result data are not cleared.
// A stalled result holds and blocks new requests until it is taken.
module stack_queue_engine (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          req_type,
	input  logic signed [31:0]  push_value,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic signed [31:0]  read_value,
	output logic                last,
	// mode register write
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);

	sqe_pkg::cell_cmd_t cmd;
	sqe_pkg::word_t     cell_d [sqe_pkg::DEPTH];

	// mode register is always writable
	assign cfg_ready = 1'b1;

	sqe_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.push_value (push_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.read_value (read_value),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.front_d    (cell_d[0]),
		.cmd        (cmd)
	);

	// Row of cells: cell 0 is the front. A front push shifts toward the back,
	// a pop shifts toward the front, list rotates the occupied span by one.
	for (genvar g = 0; g < sqe_pkg::DEPTH; g++) begin : g_cell
		sqe_pkg::word_t left_w, right_w;
		if (g == 0) begin : g_head
			assign left_w = cmd.value; // new front on a stack push
		end else begin : g_mid_l
			assign left_w = cell_d[g-1];
		end
		if (g == sqe_pkg::DEPTH - 1) begin : g_tail
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_d[g+1];
		end
		sqe_cell u_cell (
			.clk     (clk),
			.idx     (sqe_pkg::IDX_W'(g)),
			.cmd     (cmd),
			.left_d  (left_w),
			.right_d (right_w),
			.front_d (cell_d[0]),
			.d       (cell_d[g])
		);
	end

endmodule

// ===== test/testbench.sv =====
module testbench;
	import sqe_pkg::*;

	// Request codes the block must ignore: no result, no change of state.
	localparam logic [2:0] REQ_RSVD_5 = 3'd5;
	localparam logic [2:0] REQ_RSVD_6 = 3'd6;
	localparam logic [2:0] REQ_RSVD_7 = 3'd7;

	localparam logic MODE_STACK = 1'b0;
	localparam logic MODE_QUEUE = 1'b1;

	localparam int LONG_HOLD   = 200;	// cycles the result side holds off once
	localparam int SETTLE      = 8;	// cycles an ignored request may still be in flight
	localparam int TAIL_CYCLES = 80;	// longer than the longest list
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		status_t st;
		word_t   rv;
		logic    lst;
	} result_t;

	// One row of the directed table: either a mode write or a request. Rows
	// with typed set carry their one result; the others go to the predictor.
	typedef struct packed {
		logic       is_cfg;
		logic       mode;
		logic [2:0] code;
		word_t      val;
		logic       typed;
		status_t    st;
		word_t      rv;
	} step_t;

	typedef enum int {GROW_MIX, SHRINK_MIX, EVEN_MIX} mix_t;

	localparam int N_DIRECTED = 26;
	localparam step_t DIRECTED_STEPS [N_DIRECTED] = '{
		// fresh out of reset, stack mode, nothing held
		'{1'b0, MODE_STACK, REQ_LIST,   32'sd0,          1'b1, ST_EMPTY_LIST, 32'sd0},
		'{1'b0, MODE_STACK, REQ_PEEK,   32'sd0,          1'b1, ST_SHORT,      32'sd0},
		'{1'b0, MODE_STACK, REQ_POP,    32'sd0,          1'b1, ST_SHORT,      32'sd0},
		'{1'b0, MODE_STACK, REQ_SWAP,   32'sd0,          1'b1, ST_SHORT,      32'sd0},
		'{1'b0, MODE_STACK, REQ_RSVD_5, 32'sh1234_5678,  1'b0, ST_OK,         32'sd0},
		'{1'b0, MODE_STACK, REQ_PUSH,   32'sh7fff_ffff,  1'b1, ST_OK,         32'sd0},
		// swap with a single entry
		'{1'b0, MODE_STACK, REQ_SWAP,   32'sd0,          1'b1, ST_SHORT,      32'sd0},
		'{1'b0, MODE_STACK, REQ_PEEK,   32'sd0,          1'b1, ST_OK,         32'sh7fff_ffff},
		'{1'b0, MODE_STACK, REQ_PUSH,   32'sh8000_0000,  1'b1, ST_OK,         32'sd0},
		'{1'b0, MODE_STACK, REQ_PEEK,   32'sd0,          1'b1, ST_OK,         32'sh8000_0000},
		'{1'b0, MODE_STACK, REQ_SWAP,   32'sd0,          1'b1, ST_OK,         32'sd0},
		'{1'b0, MODE_STACK, REQ_PEEK,   32'sd0,          1'b0, ST_OK,         32'sd0},
		'{1'b0, MODE_STACK, REQ_LIST,   32'sd0,          1'b0, ST_OK,         32'sd0},
		// mode flips with two entries held; they stay where they are
		'{1'b1, MODE_QUEUE, REQ_PUSH,   32'sd0,          1'b0, ST_OK,         32'sd0},
		'{1'b0, MODE_STACK, REQ_PUSH,   32'sd0,          1'b0, ST_OK,         32'sd0},
		'{1'b0, MODE_STACK, REQ_PUSH,   32'shffff_ffff,  1'b0, ST_OK,         32'sd0},
		'{1'b0, MODE_STACK, REQ_RSVD_7, 32'shffff_ffff,  1'b0, ST_OK,         32'sd0},
		'{1'b0, MODE_STACK, REQ_LIST,   32'sd0,          1'b0, ST_OK,         32'sd0},
		'{1'b0, MODE_STACK, REQ_POP,    32'sd0,          1'b0, ST_OK,         32'sd0},
		'{1'b0, MODE_STACK, REQ_PEEK,   32'sd0,          1'b0, ST_OK,         32'sd0},
		'{1'b1, MODE_STACK, REQ_PUSH,   32'sd0,          1'b0, ST_OK,         32'sd0},
		'{1'b0, MODE_STACK, REQ_PUSH,   32'sh5a5a_a5a5,  1'b0, ST_OK,         32'sd0},
		'{1'b0, MODE_STACK, REQ_SWAP,   32'sd0,          1'b0, ST_OK,         32'sd0},
		'{1'b0, MODE_STACK, REQ_RSVD_6, 32'sh0f0f_0f0f,  1'b0, ST_OK,         32'sd0},
		'{1'b0, MODE_STACK, REQ_LIST,   32'sd0,          1'b0, ST_OK,         32'sd0},
		'{1'b0, MODE_STACK, REQ_POP,    32'sd0,          1'b0, ST_OK,         32'sd0}
	};

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [2:0]        req_type;
	logic signed [31:0] push_value;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        status;
	logic signed [31:0] read_value;
	logic              last;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              cfg_data;

	// Shadow of the engine: ring contents, front position, fill and mode.
	word_t   shadow_ring [DEPTH];
	idx_t    shadow_front;
	cnt_t    shadow_count;
	logic    shadow_mode;

	result_t pending_results [$];
	int      mismatches = 0;
	bit      calm = 1'b0;	// no idling on either side while set
	bit      hold_long = 1'b0;	// asks the result side for one long hold-off

	stack_queue_engine uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.push_value (push_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.read_value (read_value),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_500_000;
		$display("Regression FAIL");
		$finish;
	end

	// Works out the results of one accepted request and updates the shadow.
	task automatic model_request(input logic [2:0] code, input word_t val);
		int pos;
		word_t t;
		case (code)
			REQ_PUSH: begin
				if (shadow_count >= DEPTH) begin
					pending_results.push_back('{ST_FULL, 32'sd0, 1'b1});
				end else begin
					if (shadow_mode == MODE_STACK) begin
						shadow_front = idx_t'((int'(shadow_front) + DEPTH - 1) % DEPTH);
						shadow_ring[shadow_front] = val;
					end else begin
						pos = (int'(shadow_front) + int'(shadow_count)) % DEPTH;
						shadow_ring[pos] = val;
					end
					shadow_count = shadow_count + 1'b1;
					pending_results.push_back('{ST_OK, 32'sd0, 1'b1});
				end
			end
			REQ_LIST: begin
				if (shadow_count == 0) begin
					pending_results.push_back('{ST_EMPTY_LIST, 32'sd0, 1'b1});
				end else begin
					for (int i = 0; i < int'(shadow_count); i++) begin
						pos = (int'(shadow_front) + i) % DEPTH;
						pending_results.push_back('{ST_OK, shadow_ring[pos],
							i == int'(shadow_count) - 1});
					end
				end
			end
			REQ_PEEK: begin
				if (shadow_count == 0)
					pending_results.push_back('{ST_SHORT, 32'sd0, 1'b1});
				else
					pending_results.push_back('{ST_OK, shadow_ring[shadow_front], 1'b1});
			end
			REQ_POP: begin
				if (shadow_count == 0) begin
					pending_results.push_back('{ST_SHORT, 32'sd0, 1'b1});
				end else begin
					shadow_front = idx_t'((int'(shadow_front) + 1) % DEPTH);
					shadow_count = shadow_count - 1'b1;
					pending_results.push_back('{ST_OK, 32'sd0, 1'b1});
				end
			end
			REQ_SWAP: begin
				if (shadow_count < 2) begin
					pending_results.push_back('{ST_SHORT, 32'sd0, 1'b1});
				end else begin
					pos = (int'(shadow_front) + 1) % DEPTH;
					t = shadow_ring[shadow_front];
					shadow_ring[shadow_front] = shadow_ring[pos];
					shadow_ring[pos] = t;
					pending_results.push_back('{ST_OK, 32'sd0, 1'b1});
				end
			end
			default: ;	// spare codes: dropped by the block
		endcase
	endtask

	// Offers one request after a random gap and waits for it to be taken.
	// Valid is left high afterwards; the next call or a pause lowers it.
	task automatic send_request(input logic [2:0] code, input word_t val,
			input logic typed, input result_t typed_res);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		req_type = code;
		push_value = val;
		do @(posedge clk); while (in_stall);
		model_request(code, val);
		if (typed) begin
			void'(pending_results.pop_back());
			pending_results.push_back(typed_res);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Mode writes only go in with nothing in flight.
	task automatic write_mode(input logic m);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = m;
		do @(posedge clk); while (!cfg_ready);
		shadow_mode = m;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic word_t pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return 32'sd0;
			3: return 32'shffff_ffff;
			default: return word_t'($urandom);
		endcase
	endfunction

	// Request mix: a few spare codes as noise, the rest weighted by phase.
	function automatic logic [2:0] pick_request(input mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return 3'($urandom_range(REQ_RSVD_5, REQ_RSVD_7));
		case (mix)
			GROW_MIX: begin
				if (r < 80) return REQ_PUSH;
				if (r < 86) return REQ_PEEK;
				if (r < 92) return REQ_SWAP;
				if (r < 96) return REQ_LIST;
				return REQ_POP;
			end
			SHRINK_MIX: begin
				if (r < 15) return REQ_PUSH;
				if (r < 70) return REQ_POP;
				if (r < 80) return REQ_PEEK;
				if (r < 90) return REQ_SWAP;
				return REQ_LIST;
			end
			default: begin
				if (r < 45) return REQ_PUSH;
				if (r < 65) return REQ_POP;
				if (r < 77) return REQ_PEEK;
				if (r < 90) return REQ_SWAP;
				return REQ_LIST;
			end
		endcase
	endfunction

	task automatic send_random(input mix_t mix);
		send_request(pick_request(mix), pick_value(), 1'b0, '0);
	endtask

	task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, what, want, got);
	endtask

	// Result side: after each taken result, stall for a random count of cycles.
	// On request it holds off for a long stretch so the engine backs up.
	initial begin
		int gap;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				@(negedge clk);
				out_stall = 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall = 1'b0;
				hold_long = 1'b0;
			end else if (out_valid && !out_stall && !calm) begin
				gap = $urandom_range(0, 5);
				if (gap > 0) begin
					@(negedge clk);
					out_stall = 1'b1;
					repeat (gap) @(negedge clk);
					out_stall = 1'b0;
				end
			end
		end
	end

	// Every taken result is held against the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with none expected, status %0d value 0x%h last %b",
						$time, status, read_value, last);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st)
					flag("status", 32'(want.st), 32'(status));
				if (read_value !== want.rv)
					flag("read_value", want.rv, read_value);
				if (last !== want.lst)
					flag("last", 32'(want.lst), 32'(last));
			end
		end
	end

	initial begin
		step_t row;
		in_valid = 1'b0;
		req_type = REQ_PUSH;
		push_value = '0;
		cfg_valid = 1'b0;
		cfg_data = MODE_STACK;
		shadow_front = '0;
		shadow_count = '0;
		shadow_mode = MODE_STACK;
		foreach (shadow_ring[i])
			shadow_ring[i] = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table: edge values, every request, the short and empty-list statuses.
		for (int i = 0; i < N_DIRECTED; i++) begin
			row = DIRECTED_STEPS[i];
			if (row.is_cfg)
				write_mode(row.mode);
			else
				send_request(row.code, row.val, row.typed, '{row.st, row.rv, 1'b1});
		end

		// Queue mode: fill the ring to the top, push into a full store,
		// then read all of it back in one list.
		write_mode(MODE_QUEUE);
		while (shadow_count < DEPTH)
			send_random(GROW_MIX);
		repeat (3) send_request(REQ_PUSH, pick_value(), 1'b0, '0);
		send_request(REQ_LIST, pick_value(), 1'b0, '0);
		send_request(REQ_PEEK, pick_value(), 1'b0, '0);

		// Result side stops for a long while; requests keep coming so the
		// engine backs up and stalls its input.
		calm = 1'b1;
		hold_long = 1'b1;
		repeat (40) send_random(EVEN_MIX);
		calm = 1'b0;

		// Drain to empty, then hit the empty cases once more.
		while (shadow_count > 0)
			send_random(SHRINK_MIX);
		send_request(REQ_POP, pick_value(), 1'b0, '0);
		send_request(REQ_SWAP, pick_value(), 1'b0, '0);

		// Mixed phases under changing modes; one phase runs without idling,
		// one pauses halfway until every result is in.
		for (int s = 0; s < 5; s++) begin
			write_mode(s == 0 ? MODE_STACK : 1'($urandom_range(0, 1)));
			calm = (s == 2);
			for (int j = 0; j < 20; j++) begin
				if (s == 1 && j == 10)
					wait_drained();
				send_random(s == 3 ? SHRINK_MIX : (s == 1 ? GROW_MIX : EVEN_MIX));
			end
			calm = 1'b0;
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
